// ----- hw/rtl/cddi_pkg.sv -----
// ----------------------------------------------------------------------------
// cddi_pkg
// Shared widths, constants and control types of the disc id calculator.
// ----------------------------------------------------------------------------
package cddi_pkg;

	localparam int ADDR_W          = 19;
	localparam int SEC_W           = 13;
	localparam int ID_W            = 32;
	localparam int TRK_W           = 7;
	localparam int TOTAL_W         = 13;
	localparam int SUM_W           = 6;
	localparam int DIV_W           = 20;
	localparam int REM_W           = 7;
	localparam int SPAN_W          = 24;
	localparam int MOD_W           = 8;
	localparam int BCD_DIGITS      = 4;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int STEPS           = DIV_W;
	localparam int CNT_W           = 5;

	localparam int FRAME_OFFSET    = 150;
	localparam int FRAMES_PER_SEC  = 75;
	localparam int DIGIT_MOD       = 255;
	localparam int MAX_TRACKS_DEF  = 99;

	typedef struct packed {
		logic load;
		logic step;
	} ctl_t;

endpackage

// ----- hw/rtl/cddi_div75.sv -----
// ----------------------------------------------------------------------------
// cddi_div75
// Bit-serial restoring divider: (address + frame offset) / 75, one
// quotient bit per step, most significant first.
// ----------------------------------------------------------------------------
module cddi_div75 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cddi_pkg::ctl_t                 ctl,
	input  logic [cddi_pkg::ADDR_W-1:0]    sector_address,
	output logic                           q_bit,
	output logic [cddi_pkg::SEC_W-1:0]     seconds
);
	import cddi_pkg::*;

	logic [DIV_W-1:0] num_q;
	logic [REM_W-1:0] rem_q;
	logic [SEC_W-1:0] quo_q;
	logic [REM_W:0]   trial;
	logic             fit;

	always_comb begin
		trial = {rem_q, num_q[DIV_W-1]};
		fit   = trial >= (REM_W+1)'(FRAMES_PER_SEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctl.load) begin
			num_q <= DIV_W'(sector_address) + DIV_W'(FRAME_OFFSET);
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctl.step) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= fit ? REM_W'(trial - (REM_W+1)'(FRAMES_PER_SEC)) : trial[REM_W-1:0];
			quo_q <= {quo_q[SEC_W-2:0], fit};
		end
	end

	assign q_bit   = fit;
	assign seconds = quo_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < REM_W'(FRAMES_PER_SEC))
		else $error("divider remainder out of range");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (rem_q == '0 && quo_q == '0))
		else $error("divider not cleared on load");

	a_step_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && !ctl.load) |=> quo_q[0] == $past(fit))
		else $error("quotient bit lost");

endmodule

// ----- hw/rtl/cddi_bcd.sv -----
// ----------------------------------------------------------------------------
// cddi_bcd
// Shift-and-add-3 binary to decimal converter fed one bit per step,
// giving the decimal digit sum of the value shifted in.
// ----------------------------------------------------------------------------
module cddi_bcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cddi_pkg::ctl_t              ctl,
	input  logic                        bit_in,
	output logic [cddi_pkg::SUM_W-1:0]  digit_sum
);
	import cddi_pkg::*;

	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		digit_sum = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			digit_sum = digit_sum + SUM_W'(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
		end else if (ctl.load) begin
			bcd_q <= '0;
		end else if (ctl.step) begin
			bcd_q <= {adj[BCD_W-2:0], bit_in};
		end
	end

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_q[3:0] <= 4'd9 && bcd_q[7:4] <= 4'd9 &&
		bcd_q[11:8] <= 4'd9 && bcd_q[15:12] <= 4'd9)
		else $error("non-decimal digit");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> bcd_q == '0)
		else $error("converter not cleared on load");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!ctl.load && !ctl.step) |=> $stable(bcd_q))
		else $error("converter moved while idle");

endmodule

// ----- hw/rtl/cd_disc_id_calculator.sv -----
// ----------------------------------------------------------------------------
// cd_disc_id_calculator
// Disc id from a table of contents: track start addresses, then lead-out.
// A new word is taken only while idle (busy low); each word runs the 20 steps
// of the serial divide by 75, which feeds the decimal converter bit by bit.
// Reset: totals, track count and first seconds clear; no strobe is raised.
// Results cannot be stalled; done is high for one cycle per lead-out.
// ----------------------------------------------------------------------------
module cd_disc_id_calculator #(
	parameter int MAX_TRACKS = cddi_pkg::MAX_TRACKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cddi_pkg::ADDR_W-1:0]   sector_address,
	input  logic                          is_leadout,
	output logic                          done,
	output logic [cddi_pkg::ID_W-1:0]     disc_id,
	output logic                          disc_present
);
	import cddi_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic               leadout_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TRK_W-1:0]   tracks_q;
	logic [SEC_W-1:0]   first_q;
	logic               done_q;
	logic [ID_W-1:0]    id_q;
	logic               present_q;

	ctl_t               ctl;
	logic               accept;
	logic               q_bit;
	logic [SEC_W-1:0]   seconds;
	logic [SUM_W-1:0]   digit_sum;
	logic [MOD_W:0]     fold;
	logic [MOD_W-1:0]   total_mod;
	logic [SPAN_W-1:0]  span;
	logic [ID_W-1:0]    id_word;

	assign busy     = state_q != ST_IDLE;
	assign accept   = start && !busy;
	assign ctl.load = accept;
	assign ctl.step = state_q == ST_RUN;

	cddi_div75 u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sector_address (sector_address),
		.q_bit          (q_bit),
		.seconds        (seconds)
	);

	cddi_bcd u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.bit_in    (q_bit),
		.digit_sum (digit_sum)
	);

	// mod 255 by folding the high five bits onto the low byte
	always_comb begin
		fold = (MOD_W+1)'(total_q[TOTAL_W-1:MOD_W]) + (MOD_W+1)'(total_q[MOD_W-1:0]);
		if (fold >= (MOD_W+1)'(DIGIT_MOD)) begin
			total_mod = MOD_W'(fold - (MOD_W+1)'(DIGIT_MOD));
		end else begin
			total_mod = fold[MOD_W-1:0];
		end
		span    = SPAN_W'(seconds) - SPAN_W'(first_q);
		id_word = {total_mod, {SPAN_W{1'b0}}}
			| {span, {MOD_W{1'b0}}}
			| ID_W'(tracks_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			leadout_q <= 1'b0;
			total_q   <= '0;
			tracks_q  <= '0;
			first_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						leadout_q <= is_leadout;
						count_q   <= '0;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (count_q == CNT_W'(STEPS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					if (leadout_q) begin
						done_q   <= 1'b1;
						total_q  <= '0;
						tracks_q <= '0;
						first_q  <= '0;
					end else if (tracks_q < TRK_W'(MAX_TRACKS)) begin
						if (tracks_q == '0) begin
							first_q <= seconds;
						end
						total_q  <= total_q + TOTAL_W'(digit_sum);
						tracks_q <= tracks_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word, captured with the strobe
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && leadout_q) begin
			id_q      <= (tracks_q == '0) ? '0 : id_word;
			present_q <= tracks_q != '0;
		end
	end

	assign done         = done_q;
	assign disc_id      = id_q;
	assign disc_present = present_q;

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RUN && count_q == '0)
		else $error("accepted word did not start the divider");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE && leadout_q))
		else $error("strobe without lead-out");

	a_track_limit: assert property (@(posedge clk) disable iff (!arst_n)
		tracks_q <= TRK_W'(MAX_TRACKS))
		else $error("track count beyond limit");

	a_empty_disc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !disc_present) |-> disc_id == '0)
		else $error("id not zero for empty disc");

	a_cleared_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tracks_q == '0 && total_q == '0))
		else $error("state not cleared after lead-out");

endmodule

// ----- sim/cd_disc_id_calculator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cd_disc_id_calculator_test
// Feeds tables of contents (track starts, then lead-out) through the start /
// busy port with random gaps, predicts each disc id on acceptance and checks
// every done strobe against the oldest predicted id.
// ----------------------------------------------------------------------------
module cd_disc_id_calculator_test;

	import cddi_pkg::*;

	localparam int MAX_TRACKS = MAX_TRACKS_DEF;
	localparam int ADDR_MAX   = (1 << ADDR_W) - 1;
	localparam int CYCLE_CAP  = 400000;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic              leadout;
		int unsigned       gap;
	} toc_word_t;

	typedef struct {
		logic [ID_W-1:0] id;
		logic            present;
	} disc_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ADDR_W-1:0]   sector_address;
	logic                is_leadout;
	logic                done;
	logic [ID_W-1:0]     disc_id;
	logic                disc_present;

	toc_word_t           toc_queue[$];
	disc_result_t        pending_ids[$];
	logic                word_taken;
	int unsigned         idle_left;
	int unsigned         errors;
	int unsigned         cycles;

	// predictor state
	int unsigned         disc_digits;
	int unsigned         disc_tracks;
	int unsigned         disc_first;

	cd_disc_id_calculator #(
		.MAX_TRACKS(MAX_TRACKS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sector_address(sector_address),
		.is_leadout(is_leadout),
		.done(done),
		.disc_id(disc_id),
		.disc_present(disc_present)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned to_seconds(logic [ADDR_W-1:0] addr);
		return (int'(addr) + FRAME_OFFSET) / FRAMES_PER_SEC;
	endfunction

	function automatic int unsigned digit_sum(int unsigned v);
		int unsigned s;
		s = 0;
		while (v > 0) begin
			s += v % 10;
			v /= 10;
		end
		return s;
	endfunction

	function automatic void absorb_word(logic [ADDR_W-1:0] addr, logic leadout);
		int unsigned  secs;
		logic [31:0]  span;
		disc_result_t r;
		secs = to_seconds(addr);
		if (!leadout) begin
			if (disc_tracks < MAX_TRACKS) begin
				if (disc_tracks == 0)
					disc_first = secs;
				disc_digits = (disc_digits + digit_sum(secs)) & 32'h1fff;
				disc_tracks = (disc_tracks + 1) & 32'h7f;
			end
			return;
		end
		if (disc_tracks == 0) begin
			r.id = '0;
			r.present = 1'b0;
		end else begin
			span = secs - disc_first;
			r.id = ((disc_digits % DIGIT_MOD) << 24) | (span << 8) | disc_tracks;
			r.present = 1'b1;
		end
		pending_ids.push_back(r);
		disc_digits = 0;
		disc_tracks = 0;
		disc_first = 0;
	endfunction

	task automatic add_word(int unsigned addr, logic leadout, int unsigned gap);
		toc_word_t w;
		w.addr = addr[ADDR_W-1:0];
		w.leadout = leadout;
		w.gap = gap;
		toc_queue.push_back(w);
	endtask

	// driver
	always @(negedge clk) begin
		toc_word_t w;
		if (arst_n && !(start && !word_taken)) begin
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (toc_queue.size() > 0) begin
				w = toc_queue.pop_front();
				sector_address <= w.addr;
				is_leadout <= w.leadout;
				start <= 1'b1;
				idle_left = w.gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		disc_result_t r;
		word_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			absorb_word(sector_address, is_leadout);
		if (arst_n && done) begin
			if (pending_ids.size() == 0) begin
				$display("%0t: unexpected result, disc_id %h disc_present %b",
					$time, disc_id, disc_present);
				errors++;
			end else begin
				r = pending_ids.pop_front();
				if (disc_id !== r.id) begin
					$display("%0t: disc_id expected %h, got %h", $time, r.id, disc_id);
					errors++;
				end
				if (disc_present !== r.present) begin
					$display("%0t: disc_present expected %b, got %b",
						$time, r.present, disc_present);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_CAP) begin
			$display("%0t: timeout", $time);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned n_tracks;
		int unsigned addr;
		int unsigned gap_mode;
		int unsigned total_words;
		int unsigned i;
		bit          first_disc;

		arst_n = 1'b0;
		start = 1'b0;
		sector_address = '0;
		is_leadout = 1'b0;
		word_taken = 1'b0;
		idle_left = 0;
		errors = 0;
		cycles = 0;
		disc_digits = 0;
		disc_tracks = 0;
		disc_first = 0;

		// empty discs
		add_word(0, 1'b1, 0);
		add_word(ADDR_MAX, 1'b1, 3);
		// extremes of the address
		add_word(0, 1'b0, 0);
		add_word(ADDR_MAX, 1'b0, 0);
		add_word(ADDR_MAX, 1'b1, 1);
		// lead-out before the first track wraps the span
		add_word(ADDR_MAX, 1'b0, 2);
		add_word(0, 1'b1, 0);
		// zero span
		add_word(0, 1'b0, 9);
		add_word(0, 1'b1, 0);
		// alternating bit patterns and a typical disc
		add_word(19'h2aaaa, 1'b0, 0);
		add_word(19'h55555, 1'b0, 5);
		add_word(7350, 1'b0, 0);
		add_word(74, 1'b0, 0);
		add_word(19'h55555 + 300000, 1'b1, 0);
		add_word(224, 1'b0, 4);
		add_word(224 + 75 * 3599, 1'b1, 0);

		total_words = 0;
		first_disc = 1'b1;
		while (total_words < 1250) begin
			case ($urandom_range(0, 9))
				0: n_tracks = 0;
				1: n_tracks = $urandom_range(MAX_TRACKS - 4, MAX_TRACKS + 11);
				default: n_tracks = $urandom_range(1, 20);
			endcase
			if (first_disc)
				n_tracks = MAX_TRACKS + $urandom_range(1, 10);
			first_disc = 1'b0;
			gap_mode = $urandom_range(0, 3);
			addr = $urandom_range(0, 300);
			for (i = 0; i <= n_tracks; i++) begin
				if ($urandom_range(0, 3) == 0)
					addr = $urandom_range(0, ADDR_MAX);
				else
					addr = (addr + $urandom_range(0, n_tracks > 30 ? 5000 : 25000))
						& ADDR_MAX;
				add_word(addr, i == n_tracks, gap_mode == 0 ? 0 : $urandom_range(0, 9));
				total_words++;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (toc_queue.size() != 0 || start || pending_ids.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
